FILE: rtl/stt_pkg.sv
// Shared widths, codes, slot entry type and state encoding for the timer table.
`timescale 1ns / 1ps

package stt_pkg;

  // Field widths
  localparam int unsigned OP_W   = 2;
  localparam int unsigned TIME_W = 48;
  localparam int unsigned PER_W  = 32;
  localparam int unsigned ID_W   = 31;
  localparam int unsigned KIND_W = 3;

  // Table size default and firing limit per tick
  localparam int unsigned SLOTS_DEF   = 16;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned FIRE_CNT_W  = $clog2(MAX_RESULTS + 1);

  localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

  // Command codes
  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_SCHED  = 2'd1;
  localparam logic [OP_W-1:0] OP_CANCEL = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] EV_SCHEDULED  = 3'd0;
  localparam logic [KIND_W-1:0] EV_FIRED      = 3'd1;
  localparam logic [KIND_W-1:0] EV_CANCEL_ACK = 3'd2;
  localparam logic [KIND_W-1:0] EV_FULL       = 3'd3;
  localparam logic [KIND_W-1:0] EV_IDLE       = 3'd4;

  // One slot of the table as held in memory
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] deadline;
    logic [PER_W-1:0]  period;
    logic              periodic;
  } entry_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCHED,
    ST_WALK,
    ST_FLUSH
  } state_t;

endpackage

FILE: rtl/software_timer_table_unit.sv
// Top level of the timer table: command capture, slot sequencer and result register.
//
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_stall  opcode, current_time, interval_us,
//                                           repeat_flag, cancel_id
//  out_     output     out_valid / out_stall event_kind, timer_id, last
//
// One command is worked at a time. Tick and cancel walk the slots through the entry
// memory with registered read, one slot a cycle; a stalled result can hold the walk.
// Schedule scans the valid flags for the lowest free slot.
// Reset clears the valid flags and the id counter; no clearing pass is needed.
// A stalled result holds the walk only when a second firing needs the output.
`timescale 1ns / 1ps

module software_timer_table_unit #(
  parameter int unsigned SLOTS = stt_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [stt_pkg::OP_W-1:0]      in_opcode,
  input  logic [stt_pkg::TIME_W-1:0]    in_current_time,
  input  logic [stt_pkg::PER_W-1:0]     in_interval_us,
  input  logic                          in_repeat_flag,
  input  logic [stt_pkg::ID_W-1:0]      in_cancel_id,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [stt_pkg::KIND_W-1:0]    out_event_kind,
  output logic [stt_pkg::ID_W-1:0]      out_timer_id,
  output logic                          out_last
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [stt_pkg::FIRE_CNT_W-1:0] FIRE_LIMIT =
    stt_pkg::FIRE_CNT_W'(stt_pkg::MAX_RESULTS - 1);

  // Sequencer and command registers
  stt_pkg::state_t                   state_r, state_nxt;
  logic [stt_pkg::OP_W-1:0]          op_r;
  logic [stt_pkg::TIME_W-1:0]        now_r;
  logic [stt_pkg::PER_W-1:0]         interval_r;
  logic                              repeat_r;
  logic [stt_pkg::ID_W-1:0]          cid_r;
  logic [stt_pkg::ID_W-1:0]          id_cnt_r, id_cnt_nxt;

  // Walk pipeline: address stage and evaluate stage
  logic [IDX_W-1:0]                  a_idx_r, a_idx_nxt;
  logic                              a_more_r, a_more_nxt;
  logic                              e_valid_r, e_valid_nxt;
  logic [IDX_W-1:0]                  e_idx_r, e_idx_nxt;
  logic [stt_pkg::FIRE_CNT_W-1:0]    fire_cnt_r, fire_cnt_nxt;
  logic                              pend_valid_r, pend_valid_nxt;
  logic [stt_pkg::ID_W-1:0]          pend_id_r, pend_id_nxt;

  // Result register
  logic                              out_valid_r;
  logic [stt_pkg::KIND_W-1:0]        out_kind_r;
  logic [stt_pkg::ID_W-1:0]          out_id_r;
  logic                              out_last_r;

  // Store port signals
  logic                              rd_en;
  logic                              vld_at;
  logic                              rd_vld;
  stt_pkg::entry_t                   rd_entry;
  logic                              wr_en;
  logic [IDX_W-1:0]                  wr_idx;
  stt_pkg::entry_t                   wr_entry;
  logic                              vld_we;
  logic [IDX_W-1:0]                  vld_idx;
  logic                              vld_val;

  // Datapath terms
  logic                              in_acc;
  logic                              out_free;
  logic                              push;
  logic [stt_pkg::KIND_W-1:0]        push_kind;
  logic [stt_pkg::ID_W-1:0]          push_id;
  logic                              push_last;
  logic [stt_pkg::ID_W-1:0]          id_next;
  logic [stt_pkg::TIME_W-1:0]        since;
  logic [stt_pkg::TIME_W-1:0]        rearm;
  logic                              due;
  logic                              e_fire;
  logic                              e_match;
  logic                              e_hold;

  stt_store #(
    .SLOTS (SLOTS)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_idx   (a_idx_r),
    .vld_at   (vld_at),
    .rd_vld   (rd_vld),
    .rd_entry (rd_entry),
    .wr_en    (wr_en),
    .wr_idx   (wr_idx),
    .wr_entry (wr_entry),
    .vld_we   (vld_we),
    .vld_idx  (vld_idx),
    .vld_val  (vld_val)
  );

  assign in_stall = (state_r != stt_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Next id wraps to one, never zero
  assign id_next = (id_cnt_r == stt_pkg::ID_MAX) ? stt_pkg::ID_W'(1)
                                                 : id_cnt_r + stt_pkg::ID_W'(1);

  // Due when the deadline lies at or before now, less than half the time range behind
  assign since = now_r - rd_entry.deadline;
  assign due   = !since[stt_pkg::TIME_W-1];
  assign rearm = now_r + stt_pkg::TIME_W'(rd_entry.period);

  assign e_fire  = e_valid_r && rd_vld && due && (op_r == stt_pkg::OP_TICK);
  assign e_match = e_valid_r && rd_vld && (rd_entry.id == cid_r) &&
                   (op_r == stt_pkg::OP_CANCEL);
  // A second firing must hand the pending one to the result register
  assign e_hold  = e_fire && pend_valid_r && !out_free;

  // Capture the command word on acceptance
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r       <= in_opcode;
      now_r      <= in_current_time;
      interval_r <= in_interval_us;
      repeat_r   <= in_repeat_flag;
      cid_r      <= in_cancel_id;
    end
  end

  // Sequencer state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= stt_pkg::ST_IDLE;
      id_cnt_r     <= '0;
      a_idx_r      <= '0;
      a_more_r     <= 1'b0;
      e_valid_r    <= 1'b0;
      e_idx_r      <= '0;
      fire_cnt_r   <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      id_cnt_r     <= id_cnt_nxt;
      a_idx_r      <= a_idx_nxt;
      a_more_r     <= a_more_nxt;
      e_valid_r    <= e_valid_nxt;
      e_idx_r      <= e_idx_nxt;
      fire_cnt_r   <= fire_cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_id_r <= pend_id_nxt;
  end

  // Next state, store accesses and result pushes
  always_comb begin
    state_nxt      = state_r;
    id_cnt_nxt     = id_cnt_r;
    a_idx_nxt      = a_idx_r;
    a_more_nxt     = a_more_r;
    e_valid_nxt    = e_valid_r;
    e_idx_nxt      = e_idx_r;
    fire_cnt_nxt   = fire_cnt_r;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    wr_idx         = a_idx_r;
    wr_entry       = rd_entry;
    vld_we         = 1'b0;
    vld_idx        = a_idx_r;
    vld_val        = 1'b0;
    push           = 1'b0;
    push_kind      = stt_pkg::EV_IDLE;
    push_id        = '0;
    push_last      = 1'b0;

    case (state_r)
      stt_pkg::ST_IDLE: begin
        a_idx_nxt      = '0;
        a_more_nxt     = 1'b1;
        e_valid_nxt    = 1'b0;
        fire_cnt_nxt   = '0;
        pend_valid_nxt = 1'b0;
        if (in_valid) begin
          if (in_opcode inside {stt_pkg::OP_TICK, stt_pkg::OP_CANCEL}) begin
            state_nxt = stt_pkg::ST_WALK;
          end else if (in_opcode == stt_pkg::OP_SCHED) begin
            state_nxt = stt_pkg::ST_SCHED;
          end
        end
      end

      stt_pkg::ST_SCHED: begin
        // Take the lowest free slot, or report a full table at the end
        if (!vld_at) begin
          if (out_free) begin
            wr_en             = 1'b1;
            wr_idx            = a_idx_r;
            wr_entry.id       = id_next;
            wr_entry.deadline = now_r + stt_pkg::TIME_W'(interval_r);
            wr_entry.period   = interval_r;
            wr_entry.periodic = repeat_r;
            vld_we            = 1'b1;
            vld_idx           = a_idx_r;
            vld_val           = 1'b1;
            id_cnt_nxt        = id_next;
            push              = 1'b1;
            push_kind         = stt_pkg::EV_SCHEDULED;
            push_id           = id_next;
            push_last         = 1'b1;
            state_nxt         = stt_pkg::ST_IDLE;
          end
        end else if (a_idx_r == LAST_IDX) begin
          if (out_free) begin
            push      = 1'b1;
            push_kind = stt_pkg::EV_FULL;
            push_last = 1'b1;
            state_nxt = stt_pkg::ST_IDLE;
          end
        end else begin
          a_idx_nxt = a_idx_r + IDX_W'(1);
        end
      end

      stt_pkg::ST_WALK: begin
        if (!e_hold) begin
          // Evaluate the slot whose read was issued before
          if (e_fire) begin
            if (pend_valid_r) begin
              push      = 1'b1;
              push_kind = stt_pkg::EV_FIRED;
              push_id   = pend_id_r;
            end
            pend_valid_nxt = 1'b1;
            pend_id_nxt    = rd_entry.id;
            fire_cnt_nxt   = fire_cnt_r + stt_pkg::FIRE_CNT_W'(1);
            if (rd_entry.periodic) begin
              wr_en             = 1'b1;
              wr_idx            = e_idx_r;
              wr_entry.deadline = rearm;
            end else begin
              vld_we  = 1'b1;
              vld_idx = e_idx_r;
            end
          end
          if (e_match) begin
            vld_we  = 1'b1;
            vld_idx = e_idx_r;
          end
          // Issue the next slot read
          rd_en       = a_more_r;
          e_valid_nxt = a_more_r;
          e_idx_nxt   = a_idx_r;
          a_idx_nxt   = a_idx_r + IDX_W'(1);
          a_more_nxt  = a_more_r && (a_idx_r != LAST_IDX);
          // Stop after the last slot or once the firing limit is reached
          if (!a_more_r || (e_fire && (fire_cnt_r == FIRE_LIMIT))) begin
            e_valid_nxt = 1'b0;
            state_nxt   = stt_pkg::ST_FLUSH;
          end
        end
      end

      stt_pkg::ST_FLUSH: begin
        // Close the command with its final word
        if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          if (op_r == stt_pkg::OP_TICK) begin
            if (pend_valid_r) begin
              push_kind = stt_pkg::EV_FIRED;
              push_id   = pend_id_r;
            end else begin
              push_kind = stt_pkg::EV_IDLE;
            end
          end else begin
            push_kind = stt_pkg::EV_CANCEL_ACK;
          end
          pend_valid_nxt = 1'b0;
          state_nxt      = stt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = stt_pkg::ST_IDLE;
      end
    endcase
  end

  // Result register: load on push, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_kind_r <= push_kind;
      out_id_r   <= push_id;
      out_last_r <= push_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = out_kind_r;
  assign out_timer_id   = out_id_r;
  assign out_last       = out_last_r;

endmodule

FILE: rtl/stt_store.sv
// Slot storage: entry memory with registered read, and per-slot valid flags.
`timescale 1ns / 1ps

module stt_store #(
  parameter int unsigned SLOTS = stt_pkg::SLOTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 rd_en,
  input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] rd_idx,
  output logic                                 vld_at,
  output logic                                 rd_vld,
  output stt_pkg::entry_t                      rd_entry,
  input  logic                                 wr_en,
  input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] wr_idx,
  input  stt_pkg::entry_t                      wr_entry,
  input  logic                                 vld_we,
  input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] vld_idx,
  input  logic                                 vld_val
);

  stt_pkg::entry_t mem [SLOTS];
  stt_pkg::entry_t rd_entry_r;
  logic [SLOTS-1:0] vld_r;
  logic             rd_vld_r;

  // Write one entry, and read one entry into a registered output
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry_r <= mem[rd_idx];
    end
  end

  // Valid flags, cleared at reset; sample the flag alongside the entry read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (vld_we) begin
        vld_r[vld_idx] <= vld_val;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_idx];
      end
    end
  end

  assign vld_at   = vld_r[rd_idx];
  assign rd_vld   = rd_vld_r;
  assign rd_entry = rd_entry_r;

endmodule
